@@ src/ptt_pkg.sv @@
// Shared types and constants for the pending transfer table.
package ptt_pkg;

    // Table geometry.
    localparam int ENTRIES      = 32;
    localparam int HANDLE_WIDTH = 16;
    localparam int KEY_WIDTH    = 8;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Depth of the queue between the front end and the table engine (power of two).
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FETCH  = 2'd2,
        OP_FLUSH  = 2'd3
    } opcode_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Request payload on the input channel.
    typedef struct packed {
        logic [1:0]              opcode;
        logic [KEY_WIDTH-1:0]    endpoint_key;
        logic [HANDLE_WIDTH-1:0] transfer_handle;
    } req_t;

    // Response payload on the output channel.
    typedef struct packed {
        logic [1:0]              status;
        logic [HANDLE_WIDTH-1:0] fetched_handle;
    } rsp_t;

    // Decoded command passed from the front end to the table engine.
    typedef struct packed {
        logic                    is_add;
        logic                    is_lookup;
        logic                    is_fetch;
        logic                    is_flush;
        logic [KEY_WIDTH-1:0]    key;
        logic [HANDLE_WIDTH-1:0] handle;
    } cmd_t;

endpackage

@@ src/ptt_front.sv @@
// Front end: accepts requests, decodes the opcode and queues decoded commands.
module ptt_front
    import ptt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              decoded;
    logic              push;
    logic              pop;

    // Classify the incoming request into one-hot operation flags.
    always_comb begin
        decoded        = '0;
        decoded.key    = s_data.endpoint_key;
        decoded.handle = s_data.transfer_handle;
        unique case (opcode_t'(s_data.opcode))
            OP_ADD:    decoded.is_add    = 1'b1;
            OP_LOOKUP: decoded.is_lookup = 1'b1;
            OP_FETCH:  decoded.is_fetch  = 1'b1;
            OP_FLUSH:  decoded.is_flush  = 1'b1;
            default:   decoded.is_flush  = 1'b1;
        endcase
    end

    assign s_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ src/ptt_back.sv @@
// Table engine: slot storage, key match, free-slot search and response register.
module ptt_back
    import ptt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    typedef enum logic {
        S_SEARCH,
        S_UPDATE
    } state_t;

    state_t                  state_reg;
    logic [ENTRIES-1:0]      valid_reg;
    logic [KEY_WIDTH-1:0]    key_reg [ENTRIES];
    logic [HANDLE_WIDTH-1:0] handle_mem [ENTRIES];
    cmd_t                    cmd_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic                    free_any_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [HANDLE_WIDTH-1:0] rd_handle_reg;
    logic                    m_valid_reg;
    rsp_t                    m_data_reg;

    logic [ENTRIES-1:0]      match;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        free_idx;
    logic                    add_ok;

    // Compare the queued key against every slot in parallel.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == cmd.key);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // A command is taken once the response register will be free for it.
    assign cmd_ready = (state_reg == S_SEARCH) && (!m_valid_reg || m_ready);
    assign add_ok    = cmd_reg.is_add && !hit_reg && free_any_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Engine sequence, slot valid bits and the response register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SEARCH;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_SEARCH: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (cmd_valid && cmd_ready) begin
                        cmd_reg      <= cmd;
                        hit_reg      <= |match;
                        hit_idx_reg  <= hit_idx;
                        free_any_reg <= ~&valid_reg;
                        free_idx_reg <= free_idx;
                        state_reg    <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    m_valid_reg               <= 1'b1;
                    m_data_reg.fetched_handle <= '0;
                    m_data_reg.status         <= ST_OK;
                    if (cmd_reg.is_add) begin
                        if (hit_reg) begin
                            m_data_reg.status <= ST_DUP;
                        end else if (!free_any_reg) begin
                            m_data_reg.status <= ST_FULL;
                        end else begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                    end else if (cmd_reg.is_lookup) begin
                        m_data_reg.status <= hit_reg ? ST_OK : ST_MISS;
                    end else if (cmd_reg.is_fetch) begin
                        if (hit_reg) begin
                            m_data_reg.fetched_handle <= rd_handle_reg;
                            valid_reg[hit_idx_reg]    <= 1'b0;
                        end else begin
                            m_data_reg.status <= ST_MISS;
                        end
                    end else if (cmd_reg.is_flush) begin
                        valid_reg <= '0;
                    end
                    state_reg <= S_SEARCH;
                end
                default: begin
                    state_reg <= S_SEARCH;
                end
            endcase
        end
    end

    // Key and handle storage; the handle of the lowest match is read during the search.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_UPDATE) && add_ok) begin
            key_reg[free_idx_reg]    <= cmd_reg.key;
            handle_mem[free_idx_reg] <= cmd_reg.handle;
        end
        rd_handle_reg <= handle_mem[hit_idx];
    end

endmodule

@@ src/pending_transfer_table.sv @@
// A request passes the command queue, then the search and update steps of the engine,
// which takes a new command only after an update and once the response register is free;
// a two-entry queue lets new requests in while a response waits.
// Reset (aresetn, synchronous, active low) clears all slot valid bits, the queue and the
// response valid flag; slot keys and handles are not cleared.
// Top level of the pending transfer table: front end, command queue and table engine.
module pending_transfer_table
    import ptt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Request intake and classification.
    ptt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Table lookup, update and response.
    ptt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
